// File: src/assert_macros.svh
// Assertion shorthands shared by checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every cycle outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/tsbr_pkg.sv
package tsbr_pkg;

  localparam int RING_DEPTH_DEF  = 32;
  localparam int MESSAGE_MAX_DEF = 16;

  localparam int REC_W    = 16;
  localparam int COOKIE_W = 8;
  localparam int QUEUE_W  = 2;
  localparam int RATE_W   = 2;
  localparam int TRIES_W  = 3;
  localparam int COUNT_W  = 5;
  localparam int BYTES_W  = 6;

  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  typedef logic [REC_W-1:0] rec_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PLAN,
    ST_SEND
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic write_in;    // store incoming record at tail
    logic latch_in;    // hold incoming record until ring is drained
    logic write_held;  // store held record at tail
    logic plan;        // size next message, read its first record
    logic advance;     // output transaction taken
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic last_msg;
    logic last_drain;
  } dp_sts_t;

  function automatic rec_t pack_rec(
    input logic [COOKIE_W-1:0] cookie,
    input logic [QUEUE_W-1:0]  queue,
    input logic [RATE_W-1:0]   rate_index,
    input logic [TRIES_W-1:0]  tries,
    input logic                success
  );
    return {success, tries, rate_index, queue, cookie};
  endfunction

endpackage

// File: src/tsbr_datapath.sv
module tsbr_datapath #(
  parameter int RING_DEPTH  = tsbr_pkg::RING_DEPTH_DEF,
  parameter int MESSAGE_MAX = tsbr_pkg::MESSAGE_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tsbr_pkg::ctl_cmd_t                 cmd,
  output tsbr_pkg::dp_sts_t                  sts,
  input  logic [tsbr_pkg::COOKIE_W-1:0]      in_cookie,
  input  logic [tsbr_pkg::QUEUE_W-1:0]       in_queue,
  input  logic [tsbr_pkg::RATE_W-1:0]        in_rate_index,
  input  logic [tsbr_pkg::TRIES_W-1:0]       in_tries,
  input  logic                               in_success,
  output logic [tsbr_pkg::COOKIE_W-1:0]      out_cookie,
  output logic [tsbr_pkg::QUEUE_W-1:0]       out_queue,
  output logic [tsbr_pkg::RATE_W-1:0]        out_rate_index,
  output logic [tsbr_pkg::TRIES_W-1:0]       out_tries,
  output logic                               out_success,
  output logic [tsbr_pkg::COUNT_W-1:0]       out_message_count,
  output logic [tsbr_pkg::BYTES_W-1:0]       out_message_bytes,
  output logic                               out_last_in_message,
  output logic                               out_last_in_drain
);

  localparam int IDX_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W   = $clog2(RING_DEPTH + 1);
  localparam int MSG_LIM = (MESSAGE_MAX < RING_DEPTH) ? MESSAGE_MAX : RING_DEPTH;

  tsbr_pkg::rec_t mem [RING_DEPTH];
  tsbr_pkg::rec_t rd_data_r;
  tsbr_pkg::rec_t held_r;

  logic [IDX_W-1:0] head_r, head_nxt, head_inc;
  logic [IDX_W-1:0] tail_r, tail_nxt, tail_inc;
  logic [CNT_W-1:0] pend_r, pend_nxt;
  logic [CNT_W-1:0] msg_left_r, msg_left_nxt;
  logic [CNT_W-1:0] msg_len_r;
  logic [CNT_W-1:0] room, lim, len;
  logic             wr_en, rd_en;
  logic [IDX_W-1:0] rd_addr;
  tsbr_pkg::rec_t   wr_data;
  logic [7:0]       len8, bytes8;

  assign head_inc = (head_r == IDX_W'(RING_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == IDX_W'(RING_DEPTH - 1)) ? '0 : tail_r + 1'b1;

  // message never runs past the ring wrap
  assign room = CNT_W'(RING_DEPTH) - CNT_W'(head_r);
  assign lim  = (pend_r > CNT_W'(MSG_LIM)) ? CNT_W'(MSG_LIM) : pend_r;
  assign len  = (lim > room) ? room : lim;

  assign sts.full       = (pend_r == CNT_W'(RING_DEPTH));
  assign sts.empty      = (pend_r == '0);
  assign sts.last_msg   = (msg_left_r == CNT_W'(1));
  assign sts.last_drain = (pend_r == CNT_W'(1));

  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    pend_nxt     = pend_r;
    msg_left_nxt = msg_left_r;
    if (cmd.plan) begin
      msg_left_nxt = len;
    end
    if (cmd.advance) begin
      head_nxt     = head_inc;
      pend_nxt     = pend_r - 1'b1;
      msg_left_nxt = msg_left_r - 1'b1;
    end
    if (cmd.write_in) begin
      tail_nxt = tail_inc;
      pend_nxt = pend_r + 1'b1;
    end
    if (cmd.write_held) begin
      tail_nxt = tail_inc;
      pend_nxt = CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      tail_r     <= '0;
      pend_r     <= '0;
      msg_left_r <= '0;
    end else begin
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      pend_r     <= pend_nxt;
      msg_left_r <= msg_left_nxt;
    end
  end

  assign wr_en   = cmd.write_in | cmd.write_held;
  assign wr_data = cmd.write_held ? held_r
                 : tsbr_pkg::pack_rec(in_cookie, in_queue, in_rate_index, in_tries, in_success);
  // prefetch next record as the current one leaves
  assign rd_en   = cmd.plan | (cmd.advance & ~sts.last_msg);
  assign rd_addr = cmd.plan ? head_r : head_inc;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      held_r <= tsbr_pkg::pack_rec(in_cookie, in_queue, in_rate_index, in_tries, in_success);
    end
    if (cmd.plan) begin
      msg_len_r <= len;
    end
  end

  assign len8   = 8'(msg_len_r);
  assign bytes8 = ((len8 << 1) + 8'd3) & 8'hFC;

  assign out_cookie          = rd_data_r[7:0];
  assign out_queue           = rd_data_r[9:8];
  assign out_rate_index      = rd_data_r[11:10];
  assign out_tries           = rd_data_r[14:12];
  assign out_success         = rd_data_r[15];
  assign out_message_count   = len8[tsbr_pkg::COUNT_W-1:0];
  assign out_message_bytes   = bytes8[tsbr_pkg::BYTES_W-1:0];
  assign out_last_in_message = sts.last_msg;
  assign out_last_in_drain   = sts.last_drain;

endmodule

// File: src/tsbr_ctrl.sv
module tsbr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_func,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  tsbr_pkg::dp_sts_t   sts,
  output tsbr_pkg::ctl_cmd_t  cmd
);

  tsbr_pkg::state_t state_r, state_nxt;
  logic             store_pend_r, store_pend_nxt;
  logic             in_take, out_take;

  assign in_take  = in_valid & (state_r == tsbr_pkg::ST_IDLE);
  assign out_take = (state_r == tsbr_pkg::ST_SEND) & ~out_stall;

  always_comb begin
    state_nxt      = state_r;
    store_pend_nxt = store_pend_r;
    unique case (state_r)
      tsbr_pkg::ST_IDLE: begin
        if (in_take) begin
          if (in_func == tsbr_pkg::FUNC_FLUSH) begin
            if (!sts.empty) state_nxt = tsbr_pkg::ST_PLAN;
          end else if (sts.full) begin
            state_nxt      = tsbr_pkg::ST_PLAN;
            store_pend_nxt = 1'b1;
          end
        end
      end
      tsbr_pkg::ST_PLAN: begin
        state_nxt = tsbr_pkg::ST_SEND;
      end
      tsbr_pkg::ST_SEND: begin
        if (out_take) begin
          if (sts.last_drain) begin
            state_nxt      = tsbr_pkg::ST_IDLE;
            store_pend_nxt = 1'b0;
          end else if (sts.last_msg) begin
            state_nxt = tsbr_pkg::ST_PLAN;
          end
        end
      end
      default: state_nxt = tsbr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      tsbr_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_take && in_func == tsbr_pkg::FUNC_STORE) begin
          cmd.write_in = ~sts.full;
          cmd.latch_in = sts.full;
        end
      end
      tsbr_pkg::ST_PLAN: begin
        cmd.plan = 1'b1;
      end
      tsbr_pkg::ST_SEND: begin
        out_valid      = 1'b1;
        cmd.advance    = out_take;
        cmd.write_held = out_take & sts.last_drain & store_pend_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tsbr_pkg::ST_IDLE;
      store_pend_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      store_pend_r <= store_pend_nxt;
    end
  end

endmodule

// File: src/tx_status_batch_ring_top.sv
// Store transaction into a non-full ring: taken when idle without stalling, no results.
// Flush of a non-empty ring, or store into a full ring: input stalls; each
// message starts with a planning state, then sends one record per cycle, held
// while out_stall is high, from the registered ring read.
// Reset (rst_n low, synchronous) empties the ring; record storage is not cleared.
module tx_status_batch_ring_top #(
  parameter int RING_DEPTH  = tsbr_pkg::RING_DEPTH_DEF,
  parameter int MESSAGE_MAX = tsbr_pkg::MESSAGE_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_func,
  input  logic [tsbr_pkg::COOKIE_W-1:0]  in_cookie,
  input  logic [tsbr_pkg::QUEUE_W-1:0]   in_queue,
  input  logic [tsbr_pkg::RATE_W-1:0]    in_rate_index,
  input  logic [tsbr_pkg::TRIES_W-1:0]   in_tries,
  input  logic                           in_success,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tsbr_pkg::COOKIE_W-1:0]  out_cookie,
  output logic [tsbr_pkg::QUEUE_W-1:0]   out_queue,
  output logic [tsbr_pkg::RATE_W-1:0]    out_rate_index,
  output logic [tsbr_pkg::TRIES_W-1:0]   out_tries,
  output logic                           out_success,
  output logic [tsbr_pkg::COUNT_W-1:0]   out_message_count,
  output logic [tsbr_pkg::BYTES_W-1:0]   out_message_bytes,
  output logic                           out_last_in_message,
  output logic                           out_last_in_drain
);

  tsbr_pkg::ctl_cmd_t cmd;
  tsbr_pkg::dp_sts_t  sts;

  tsbr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tsbr_datapath #(
    .RING_DEPTH  (RING_DEPTH),
    .MESSAGE_MAX (MESSAGE_MAX)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_cookie           (in_cookie),
    .in_queue            (in_queue),
    .in_rate_index       (in_rate_index),
    .in_tries            (in_tries),
    .in_success          (in_success),
    .out_cookie          (out_cookie),
    .out_queue           (out_queue),
    .out_rate_index      (out_rate_index),
    .out_tries           (out_tries),
    .out_success         (out_success),
    .out_message_count   (out_message_count),
    .out_message_bytes   (out_message_bytes),
    .out_last_in_message (out_last_in_message),
    .out_last_in_drain   (out_last_in_drain)
  );

endmodule

// File: src/tsbr_checker.sv
`include "assert_macros.svh"

module tsbr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [tsbr_pkg::COOKIE_W-1:0]  out_cookie,
  input logic [tsbr_pkg::COUNT_W-1:0]   out_message_count,
  input logic [tsbr_pkg::BYTES_W-1:0]   out_message_bytes,
  input logic                           out_last_in_message,
  input logic                           out_last_in_drain
);

  logic [7:0] exp_bytes;

  assign exp_bytes = (((8'(out_message_count)) << 1) + 8'd3) & 8'hFC;

  // no input taken while a drain is emitting
  `ASSERT_IMPLIES(a_stall_in_drain, clk, rst_n, out_valid, in_stall, "input open during drain")
  `ASSERT_IMPLIES(a_drain_end_msg, clk, rst_n, out_valid && out_last_in_drain,
    out_last_in_message, "drain ends inside a message")
  `ASSERT_IMPLIES(a_bytes, clk, rst_n, out_valid,
    out_message_bytes == exp_bytes[5:0], "message size mismatch")
  `ASSERT_NEXT(a_msg_burst, clk, rst_n, out_valid && !out_stall && !out_last_in_message,
    out_valid, "gap inside a message")
  `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_cookie), "stalled transaction changed")

endmodule

bind tx_status_batch_ring_top tsbr_checker u_tsbr_checker (.*);
